>>> rtl/pmvg_pkg.sv
// Shared types, constants and arithmetic helpers of the primitive mesh vertex generator.
package pmvg_pkg;

  // Default grid index width
  localparam int unsigned SEG_BITS_DEF = 8;

  // Fixed-point widths
  localparam int unsigned TEX_W  = 17;   // Q1.16 texture coordinate
  localparam int unsigned POS_W  = 32;   // signed Q16.16 position
  localparam int unsigned EXT_W  = 31;   // unsigned Q15.16 size
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned ANG_W  = 16;   // quarter-wave argument 0..32768
  localparam int unsigned SIN_W  = 17;   // unsigned Q16 sine magnitude
  localparam int unsigned QUARTER = 32768;

  // Divider shape: quotient bits resolved per register stage
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = (TEX_W + DIV_STEPS - 1) / DIV_STEPS;

  // Quarter-sine polynomial: coefficient count and unit latency
  localparam int unsigned NCOEF     = 5;
  localparam int unsigned HORNER    = NCOEF - 1;
  localparam int unsigned QSIN_LAT  = HORNER + 2;
  // Stages from the plane/cube result to the output stage
  localparam int unsigned SIDE_LEN  = QSIN_LAT + 3;

  // Taylor coefficients of sin(pi/2 * x), Q30
  localparam logic [30:0] SIN_COEF [NCOEF] = '{
    31'd1686629713, 31'd693598668, 31'd85569304, 31'd5026994, 31'd172272
  };

  // Shape modes
  localparam logic [1:0] MODE_PLANE  = 2'd0;
  localparam logic [1:0] MODE_SPHERE = 2'd1;
  localparam logic [1:0] MODE_CUBE   = 2'd2;
  localparam logic [1:0] MODE_BAD    = 2'd3;

  // Cube faces
  localparam logic [2:0] FACE_PZ = 3'd0;
  localparam logic [2:0] FACE_PX = 3'd1;
  localparam logic [2:0] FACE_NZ = 3'd2;
  localparam logic [2:0] FACE_NX = 3'd3;
  localparam logic [2:0] FACE_PY = 3'd4;
  localparam logic [2:0] FACE_NY = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGS_U     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEGS_V     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd7;

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  // Per-item control carried beside the divider
  typedef struct packed {
    logic [1:0] mode;
    logic       err;
    logic [2:0] face;
  } front_t;

  // Per-item data carried down the back half of the pipeline
  typedef struct packed {
    logic [1:0]       mode;
    logic             err;
    logic [2:0]       face;
    logic [1:0]       qphi;
    logic [1:0]       qth;
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
  } side_t;

  // Scale a Q16 product back, rounding half away from zero
  function automatic logic signed [33:0] round_q16(input logic signed [49:0] p);
    logic [50:0] mag;
    logic [50:0] sum;
    logic [33:0] r;
    mag = p[49] ? (~{p[49], p} + 51'd1) : {1'b0, p};
    sum = mag + 51'd32768;
    r   = sum[49:16];
    return p[49] ? -$signed(r) : $signed(r);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [POS_W-1:0] sat32(input logic signed [33:0] v);
    logic [POS_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/pmvg_div.sv
// Pipelined restoring divider producing the Q1.16 texture fraction.
module pmvg_div #(
  parameter int unsigned SEG_BITS = pmvg_pkg::SEG_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [SEG_BITS+pmvg_pkg::TEX_W-1:0]     num_i,
  input  logic [SEG_BITS-1:0]                     den_i,
  output logic [pmvg_pkg::TEX_W-1:0]              quo_o
);
  import pmvg_pkg::*;

  logic [SEG_BITS-1:0] rem_q [DIV_STAGES];
  logic [TEX_W-1:0]    low_q [DIV_STAGES];
  logic [TEX_W-1:0]    quo_q [DIV_STAGES];
  logic [SEG_BITS-1:0] den_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [SEG_BITS-1:0] rem_in;
    logic [TEX_W-1:0]    low_in;
    logic [TEX_W-1:0]    quo_in;
    logic [SEG_BITS-1:0] den_in;
    logic [SEG_BITS-1:0] rem_d;
    logic [TEX_W-1:0]    low_d;
    logic [TEX_W-1:0]    quo_d;

    if (g == 0) begin : g_first
      assign rem_in = num_i[SEG_BITS+TEX_W-1:TEX_W];
      assign low_in = num_i[TEX_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign low_in = low_q[g-1];
      assign quo_in = quo_q[g-1];
      assign den_in = den_q[g-1];
    end

    // Resolve a few quotient bits, shifting in one dividend bit each
    always_comb begin
      logic [SEG_BITS:0] wide;
      logic              qbit;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (g * DIV_STEPS + j < TEX_W) begin
          wide = {rem_d, low_d[TEX_W-1]};
          qbit = (wide >= {1'b0, den_in});
          if (qbit) begin
            wide = wide - {1'b0, den_in};
          end
          rem_d = wide[SEG_BITS-1:0];
          low_d = {low_d[TEX_W-2:0], 1'b0};
          quo_d = {quo_d[TEX_W-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        low_q[g] <= low_d;
        quo_q[g] <= quo_d;
        den_q[g] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

>>> rtl/pmvg_qsin.sv
// Pipelined quarter-wave sine: degree-9 odd polynomial in Horner form, Q16 out.
module pmvg_qsin (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pmvg_pkg::ANG_W-1:0]   ang_i,
  output logic [pmvg_pkg::SIN_W-1:0]   sin_o
);
  import pmvg_pkg::*;

  logic [30:0]      x_q  [HORNER+1];
  logic [30:0]      x2_q [HORNER];
  logic [30:0]      p_q  [HORNER];
  logic [SIN_W-1:0] out_q;

  // Square the Q30 argument
  logic [30:0] x_in;
  logic [61:0] sq;
  assign x_in = {ang_i, 15'd0};
  assign sq   = 62'(x_in) * 62'(x_in);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= x_in;
      x2_q[0] <= sq[60:30];
    end
  end

  // Horner steps, one multiply per stage
  for (genvar k = 0; k < HORNER; k++) begin : g_horner
    logic [30:0] p_in;
    logic [61:0] prod;
    logic [31:0] diff;

    if (k == 0) begin : g_first
      assign p_in = SIN_COEF[NCOEF-1];
    end else begin : g_next
      assign p_in = p_q[k-1];
    end

    assign prod = 62'(x2_q[k]) * 62'(p_in);
    assign diff = {1'b0, SIN_COEF[NCOEF-2-k]} - prod[61:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k]   <= diff[30:0];
        x_q[k+1] <= x_q[k];
      end
    end

    if (k < HORNER - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x2_q[k+1] <= x2_q[k];
        end
      end
    end
  end

  // Final odd factor, clamp and round to the nearest Q16 value
  logic [61:0] fin;
  logic [31:0] s_q30;
  logic [31:0] s_rnd;
  logic [SIN_W-1:0] s_q16;
  assign fin = 62'(x_q[HORNER]) * 62'(p_q[HORNER-1]);

  always_comb begin
    s_q30 = fin[61:30];
    if (s_q30 > 32'd1073741824) begin
      s_q30 = 32'd1073741824;
    end
    s_rnd = (s_q30 + 32'd8192) >> 14;
    if (s_rnd > 32'd65536) begin
      s_q16 = SIN_W'(65536);
    end else begin
      s_q16 = s_rnd[SIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= s_q16;
    end
  end

  assign sin_o = out_q;

endmodule

>>> rtl/primitive_mesh_vertex_generator.sv
// Top level of the plane / UV-sphere / cube grid vertex generator.
//
// Input stream: one grid point per item (face, col, row) on s_axis_*.
// Output stream: one vertex per item on m_axis_*: position in signed
// Q16.16 (x, y, z), texture coordinate in Q1.16 (u, v), and a range flag
// on tuser; a flagged vertex carries zeros in every other field.
// Configuration: cfg_valid_i / cfg_index_i / cfg_data_i write the shape
// mode, segment counts, plane origin, extents and sphere radius; write
// them only while no item is in flight. The port is always ready.
// Throughput: one item per cycle while the pipeline is not stalled. Items
// pass eighteen register stages: one input stage, six divider stages (up
// to three quotient bits each), one product stage, six quarter-sine
// polynomial stages, three sphere scaling stages and the output register.
// Stall: the whole pipeline holds while the output register is full and
// not taken; s_axis_tready is high whenever the output register is empty
// or being emptied, so no item is lost or repeated.
// Reset: clears all valid bits and restores the register defaults.
module primitive_mesh_vertex_generator #(
  parameter int unsigned SEG_BITS = pmvg_pkg::SEG_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: face[2:0], col, row (SEG_BITS each), zero fill
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((3+2*SEG_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tdata: pos_x, pos_y, pos_z (32 each), tex_u, tex_v (17 each), zero fill
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [135:0]                      m_axis_tdata,
  // tuser: range_error
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pmvg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);
  import pmvg_pkg::*;

  localparam int unsigned NUM_W = SEG_BITS + TEX_W;
  localparam int unsigned T_IDX = DIV_STAGES + 1;
  localparam int unsigned NSTG  = T_IDX + SIDE_LEN + 2;

  // ---------------- configuration registers ----------------
  logic [1:0]          shape_mode_q;
  logic [SEG_BITS-1:0] segs_u_q, segs_v_q;
  logic [POS_W-1:0]    origin_x_q, origin_y_q;
  logic [EXT_W-1:0]    extent_x_q, extent_y_q, radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_mode_q <= MODE_PLANE;
      segs_u_q     <= SEG_BITS'(1);
      segs_v_q     <= SEG_BITS'(1);
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      extent_x_q   <= EXT_W'(65536);
      extent_y_q   <= EXT_W'(65536);
      radius_q     <= EXT_W'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SHAPE_MODE: shape_mode_q <= cfg_data_i[1:0];
        REG_SEGS_U:     segs_u_q     <= cfg_data_i[SEG_BITS-1:0];
        REG_SEGS_V:     segs_v_q     <= cfg_data_i[SEG_BITS-1:0];
        REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        REG_EXTENT_X:   extent_x_q   <= cfg_data_i[EXT_W-1:0];
        REG_EXTENT_Y:   extent_y_q   <= cfg_data_i[EXT_W-1:0];
        REG_RADIUS:     radius_q     <= cfg_data_i[EXT_W-1:0];
        default:        ;
      endcase
    end
  end

  // ---------------- pipeline valid bits ----------------
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en            = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSTG-1];

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // ---------------- input stage ----------------
  logic [2:0]          face_q;
  logic [SEG_BITS-1:0] col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      face_q <= s_axis_tdata[2:0];
      col_q  <= s_axis_tdata[3 +: SEG_BITS];
      row_q  <= s_axis_tdata[3+SEG_BITS +: SEG_BITS];
    end
  end

  // Effective segment counts, range check, divider operands
  logic [SEG_BITS-1:0] su, sv;
  logic                is_cube, err;
  logic [NUM_W-1:0]    num_u, num_v;
  front_t              front;

  always_comb begin
    is_cube = (shape_mode_q == MODE_CUBE);
    su = (segs_u_q == '0) ? SEG_BITS'(1) : segs_u_q;
    if (is_cube) begin
      sv = su;
    end else begin
      sv = (segs_v_q == '0) ? SEG_BITS'(1) : segs_v_q;
    end
    err = (shape_mode_q == MODE_BAD) || (col_q > su) || (row_q > sv) ||
          (is_cube && (face_q > FACE_NY));
    num_u = NUM_W'({col_q, 16'd0}) + NUM_W'(su >> 1);
    num_v = NUM_W'({row_q, 16'd0}) + NUM_W'(sv >> 1);
    front.mode = shape_mode_q;
    front.err  = err;
    front.face = face_q;
  end

  // ---------------- texture fraction dividers ----------------
  logic [TEX_W-1:0] tu_div, tv_div;

  pmvg_div #(.SEG_BITS(SEG_BITS)) u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_u),
    .den_i (su),
    .quo_o (tu_div)
  );

  pmvg_div #(.SEG_BITS(SEG_BITS)) u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_v),
    .den_i (sv),
    .quo_o (tv_div)
  );

  // Delay the item control beside the dividers
  front_t dfront_q [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dfront_q[0] <= front;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dfront_q[i] <= dfront_q[i-1];
      end
    end
  end

  // ---------------- product stage ----------------
  logic [TEX_W-1:0] phi, theta;
  side_t            t_side;
  logic [47:0]      prod_ax_q, prod_by_q, prod_bx_q;
  side_t            t_q;
  logic [14:0]      fphi_q, fth_q;

  always_comb begin
    phi   = tv_div + TEX_W'(98304);
    theta = {tu_div[TEX_W-2:0], 1'b0};
    t_side.mode = dfront_q[DIV_STAGES-1].mode;
    t_side.err  = dfront_q[DIV_STAGES-1].err;
    t_side.face = dfront_q[DIV_STAGES-1].face;
    t_side.qphi = phi[16:15];
    t_side.qth  = theta[16:15];
    t_side.tu   = tu_div;
    t_side.tv   = tv_div;
    t_side.px   = '0;
    t_side.py   = '0;
    t_side.pz   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q       <= t_side;
      fphi_q    <= phi[14:0];
      fth_q     <= theta[14:0];
      prod_ax_q <= 48'(extent_x_q) * 48'(tu_div);
      prod_by_q <= 48'(extent_y_q) * 48'(tv_div);
      prod_bx_q <= 48'(extent_x_q) * 48'(tv_div);
    end
  end

  // ---------------- quarter-sine units ----------------
  logic [ANG_W-1:0] ang_phi_a, ang_phi_b, ang_th_a, ang_th_b;
  logic [SIN_W-1:0] qs_phi_a, qs_phi_b, qs_th_a, qs_th_b;

  assign ang_phi_a = {1'b0, fphi_q};
  assign ang_phi_b = ANG_W'(QUARTER) - {1'b0, fphi_q};
  assign ang_th_a  = {1'b0, fth_q};
  assign ang_th_b  = ANG_W'(QUARTER) - {1'b0, fth_q};

  pmvg_qsin u_qs_phi_a (.clk_i(clk_i), .en_i(en), .ang_i(ang_phi_a), .sin_o(qs_phi_a));
  pmvg_qsin u_qs_phi_b (.clk_i(clk_i), .en_i(en), .ang_i(ang_phi_b), .sin_o(qs_phi_b));
  pmvg_qsin u_qs_th_a  (.clk_i(clk_i), .en_i(en), .ang_i(ang_th_a),  .sin_o(qs_th_a));
  pmvg_qsin u_qs_th_b  (.clk_i(clk_i), .en_i(en), .ang_i(ang_th_b),  .sin_o(qs_th_b));

  // ---------------- plane and cube positions ----------------
  logic [31:0]        a_x, b_y, b_x, h;
  logic signed [33:0] as, bys, bxs, hs, ox, oy;
  side_t              r_side;
  side_t              sd_q [SIDE_LEN];

  always_comb begin
    logic [47:0] t0, t1, t2;
    t0  = prod_ax_q + 48'd32768;
    t1  = prod_by_q + 48'd32768;
    t2  = prod_bx_q + 48'd32768;
    a_x = t0[47:16];
    b_y = t1[47:16];
    b_x = t2[47:16];
    h   = {2'b00, extent_x_q[EXT_W-1:1]};
    as  = $signed({2'b00, a_x});
    bys = $signed({2'b00, b_y});
    bxs = $signed({2'b00, b_x});
    hs  = $signed({2'b00, h});
    ox  = $signed({{2{origin_x_q[31]}}, origin_x_q});
    oy  = $signed({{2{origin_y_q[31]}}, origin_y_q});
    r_side = t_q;
    if (t_q.mode == MODE_CUBE) begin
      unique case (t_q.face)
        FACE_PZ: begin
          r_side.px = sat32(as - hs);  r_side.py = sat32(bxs - hs); r_side.pz = sat32(hs);
        end
        FACE_PX: begin
          r_side.px = sat32(hs);       r_side.py = sat32(bxs - hs); r_side.pz = sat32(hs - as);
        end
        FACE_NZ: begin
          r_side.px = sat32(hs - as);  r_side.py = sat32(bxs - hs); r_side.pz = sat32(-hs);
        end
        FACE_NX: begin
          r_side.px = sat32(-hs);      r_side.py = sat32(bxs - hs); r_side.pz = sat32(as - hs);
        end
        FACE_PY: begin
          r_side.px = sat32(as - hs);  r_side.py = sat32(hs);       r_side.pz = sat32(hs - bxs);
        end
        default: begin
          r_side.px = sat32(as - hs);  r_side.py = sat32(-hs);      r_side.pz = sat32(bxs - hs);
        end
      endcase
    end else begin
      r_side.px = sat32(ox + as);
      r_side.py = sat32(oy + bys);
      r_side.pz = '0;
    end
  end

  // Carry plane/cube results and item control alongside the sine units and sphere scaling
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= r_side;
      for (int i = 1; i < SIDE_LEN; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // ---------------- sphere scaling ----------------
  localparam int unsigned M1_IDX = QSIN_LAT - 1;

  logic signed [SIN_W:0] sphi, cphi, sth, cth;
  logic signed [49:0]    m1_rcp_q, m1_pyp_q;
  logic signed [SIN_W:0] m1_cth_q, m1_sth_q, m2_cth_q, m2_sth_q;
  logic signed [31:0]    m2_rc_q, m2_py_q, m3_py_q;
  logic signed [49:0]    m3_pxp_q, m3_pzp_q;
  logic signed [33:0]    m2_rc_w, m2_py_w;

  // Fold quadrants: pick the mirrored argument and the sign
  always_comb begin
    logic [1:0] qp, qt;
    logic signed [SIN_W:0] sa, sb, ta, tb;
    qp = sd_q[M1_IDX].qphi;
    qt = sd_q[M1_IDX].qth;
    sa = $signed({1'b0, qs_phi_a});
    sb = $signed({1'b0, qs_phi_b});
    ta = $signed({1'b0, qs_th_a});
    tb = $signed({1'b0, qs_th_b});
    sphi = qp[0] ? sb : sa;
    cphi = qp[0] ? sa : sb;
    sth  = qt[0] ? tb : ta;
    cth  = qt[0] ? ta : tb;
    if (qp[1])         sphi = -sphi;
    if (qp[1] ^ qp[0]) cphi = -cphi;
    if (qt[1])         sth  = -sth;
    if (qt[1] ^ qt[0]) cth  = -cth;
  end

  assign m2_rc_w = round_q16(m1_rcp_q);
  assign m2_py_w = round_q16(m1_pyp_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // scale by radius
      m1_rcp_q <= 50'($signed({1'b0, radius_q}) * cphi);
      m1_pyp_q <= 50'($signed({1'b0, radius_q}) * sphi);
      m1_cth_q <= cth;
      m1_sth_q <= sth;
      // round ring radius and height
      m2_rc_q  <= m2_rc_w[31:0];
      m2_py_q  <= m2_py_w[31:0];
      m2_cth_q <= m1_cth_q;
      m2_sth_q <= m1_sth_q;
      // spread the ring around the pole axis
      m3_pxp_q <= 50'(m2_rc_q * m2_cth_q);
      m3_pzp_q <= 50'(m2_rc_q * m2_sth_q);
      m3_py_q  <= m2_py_q;
    end
  end

  // ---------------- output register ----------------
  side_t              fin;
  logic signed [33:0] sx, sz;
  logic [POS_W-1:0]   ox_d, oy_d, oz_d;
  logic [TEX_W-1:0]   ou_d, ov_d;
  logic [POS_W-1:0]   pos_x_q, pos_y_q, pos_z_q;
  logic [TEX_W-1:0]   tex_u_q, tex_v_q;
  logic               range_error_q;

  always_comb begin
    fin = sd_q[SIDE_LEN-1];
    sx  = round_q16(m3_pxp_q);
    sz  = -round_q16(m3_pzp_q);
    if (fin.mode == MODE_SPHERE) begin
      ox_d = sat32(sx);
      oy_d = m3_py_q;
      oz_d = sat32(sz);
    end else begin
      ox_d = fin.px;
      oy_d = fin.py;
      oz_d = fin.pz;
    end
    ou_d = fin.tu;
    ov_d = fin.tv;
    // drop every field of an out-of-range item
    if (fin.err) begin
      ox_d = '0;
      oy_d = '0;
      oz_d = '0;
      ou_d = '0;
      ov_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q       <= ox_d;
      pos_y_q       <= oy_d;
      pos_z_q       <= oz_d;
      tex_u_q       <= ou_d;
      tex_v_q       <= ov_d;
      range_error_q <= fin.err;
    end
  end

  assign m_axis_tdata = {6'd0, tex_v_q, tex_u_q, pos_z_q, pos_y_q, pos_x_q};
  assign m_axis_tuser = range_error_q;

endmodule

>>> dv/primitive_mesh_vertex_generator_tb.sv
// Testbench for the plane / UV-sphere / cube grid vertex generator.
`timescale 1ns / 1ps

module primitive_mesh_vertex_generator_tb;
  import pmvg_pkg::*;

  localparam int unsigned SB = 8;
  localparam int unsigned IN_W = ((3 + 2 * SB + 7) / 8) * 8;
  localparam int unsigned LAT = 18;

  typedef struct packed {
    logic [2:0]    face;
    logic [SB-1:0] col;
    logic [SB-1:0] row;
  } grid_pt_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [16:0] tu;
    logic [16:0] tv;
    logic        err;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  primitive_mesh_vertex_generator #(.SEG_BITS(SB)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers
  logic [1:0]  sh_mode;
  logic [7:0]  sh_su, sh_sv;
  logic [31:0] sh_ox, sh_oy;
  logic [30:0] sh_ex, sh_ey, sh_rad;

  grid_pt_t pending_pts[$];
  vertex_t  expected_verts[$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_off_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  // Scale by a Q16 fraction, rounding half away from zero
  function automatic longint scale_q16(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p >= 0) return (p + 32768) / 65536;
    return -((-p + 32768) / 65536);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Quarter-wave sine on 0..32768, Q16 result
  function automatic longint qsine(input int unsigned f);
    longint unsigned coef[5];
    longint unsigned x, x2, p, s;
    coef = '{64'd1686629713, 64'd693598668, 64'd85569304, 64'd5026994, 64'd172272};
    x = longint'(f) << 15;
    x2 = (x * x) >> 30;
    p = coef[4];
    for (int i = 3; i >= 0; i--) p = coef[i] - ((x2 * p) >> 30);
    s = (x * p) >> 30;
    if (s > 64'd1073741824) s = 64'd1073741824;
    s = (s + 8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return longint'(s);
  endfunction

  // Sine of an angle in 1/131072 turns
  function automatic longint turn_sine(input int unsigned a);
    int unsigned q, f;
    a = a & 32'h1FFFF;
    q = (a >> 15) & 3;
    f = a & 32767;
    case (q)
      0: return qsine(f);
      1: return qsine(32768 - f);
      2: return -qsine(f);
      default: return -qsine(32768 - f);
    endcase
  endfunction

  function automatic int unsigned tex_coord(input int unsigned idx, input int unsigned segs);
    return 32'(((longint'(idx) << 16) + (segs >> 1)) / segs);
  endfunction

  function automatic vertex_t vertex_of(input grid_pt_t pt);
    vertex_t v;
    int unsigned su, sv, tu, tv, phi, th;
    longint px, py, pz, rc, h, a, b;
    bit cube;
    v = '0;
    px = 0; py = 0; pz = 0;
    su = (sh_su == 0) ? 1 : sh_su;
    sv = (sh_sv == 0) ? 1 : sh_sv;
    cube = (sh_mode == MODE_CUBE);
    if (cube) sv = su;
    v.err = (sh_mode == MODE_BAD) || pt.col > su || pt.row > sv || (cube && pt.face > 5);
    if (v.err) return v;
    tu = tex_coord(pt.col, su);
    tv = tex_coord(pt.row, sv);
    if (sh_mode == MODE_PLANE) begin
      px = longint'($signed(sh_ox)) + scale_q16(sh_ex, tu);
      py = longint'($signed(sh_oy)) + scale_q16(sh_ey, tv);
    end else if (sh_mode == MODE_SPHERE) begin
      phi = (tv + 131072 - 32768) & 32'h1FFFF;
      th = (tu << 1) & 32'h1FFFF;
      rc = scale_q16(sh_rad, turn_sine(phi + 32768));
      px = scale_q16(rc, turn_sine(th + 32768));
      py = scale_q16(sh_rad, turn_sine(phi));
      pz = -scale_q16(rc, turn_sine(th));
    end else begin
      h = sh_ex >> 1;
      a = scale_q16(sh_ex, tu);
      b = scale_q16(sh_ex, tv);
      case (pt.face)
        FACE_PZ: begin px = a - h; py = b - h; pz = h; end
        FACE_PX: begin px = h; py = b - h; pz = h - a; end
        FACE_NZ: begin px = h - a; py = b - h; pz = -h; end
        FACE_NX: begin px = -h; py = b - h; pz = a - h; end
        FACE_PY: begin px = a - h; py = h; pz = h - b; end
        default: begin px = a - h; py = -h; pz = b - h; end
      endcase
    end
    v.px = 32'(clamp32(px));
    v.py = 32'(clamp32(py));
    v.pz = 32'(clamp32(pz));
    v.tu = 17'(tu);
    v.tv = 17'(tv);
    return v;
  endfunction

  // Feed grid points from the pending queue, predicting on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_verts.push_back(vertex_of(pending_pts.pop_front()));
      end
      if (s_axis_tvalid && !(s_axis_tready)) begin
        // hold the item
      end else if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'({pending_pts[0].row, pending_pts[0].col, pending_pts[0].face});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Check vertices against the oldest expectation
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verts.size() == 0) begin
          $display("unexpected vertex %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_verts.pop_front();
          if (m_axis_tdata[31:0] !== want.px) report_mismatch("pos_x", m_axis_tdata[31:0], want.px);
          if (m_axis_tdata[63:32] !== want.py) report_mismatch("pos_y", m_axis_tdata[63:32], want.py);
          if (m_axis_tdata[95:64] !== want.pz) report_mismatch("pos_z", m_axis_tdata[95:64], want.pz);
          if (m_axis_tdata[112:96] !== want.tu)
            report_mismatch("tex_u", 32'(m_axis_tdata[112:96]), 32'(want.tu));
          if (m_axis_tdata[129:113] !== want.tv)
            report_mismatch("tex_v", 32'(m_axis_tdata[129:113]), 32'(want.tv));
          if (m_axis_tuser !== want.err)
            report_mismatch("range_error", 32'(m_axis_tuser), 32'(want.err));
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SHAPE_MODE: sh_mode = val[1:0];
      REG_SEGS_U:     sh_su = val[7:0];
      REG_SEGS_V:     sh_sv = val[7:0];
      REG_ORIGIN_X:   sh_ox = val;
      REG_ORIGIN_Y:   sh_oy = val;
      REG_EXTENT_X:   sh_ex = val[30:0];
      REG_EXTENT_Y:   sh_ey = val[30:0];
      default:        sh_rad = val[30:0];
    endcase
  endtask

  // Wait until every queued point is sent and every vertex is back
  task automatic drain();
    while (pending_pts.size() > 0 || expected_verts.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  function automatic logic [30:0] rand_size();
    case ($urandom_range(3))
      0: return 31'($urandom_range(0, 3));
      1: return 31'h7FFF_FFFF - 31'($urandom_range(3));
      default: return 31'($urandom_range(1 << 20));
    endcase
  endfunction

  // Push a random point, mostly inside the configured grid
  task automatic push_random();
    grid_pt_t pt;
    int unsigned su, sv;
    su = (sh_su == 0) ? 1 : sh_su;
    sv = (sh_mode == MODE_CUBE) ? su : ((sh_sv == 0) ? 1 : sh_sv);
    pt.face = (sh_mode == MODE_CUBE && $urandom_range(9) != 0) ? 3'($urandom_range(5))
                                                               : 3'($urandom);
    if ($urandom_range(9) == 0) begin
      pt.col = SB'($urandom);
      pt.row = SB'($urandom);
    end else begin
      pt.col = SB'($urandom_range(su));
      pt.row = SB'($urandom_range(sv));
    end
    pending_pts.push_back(pt);
  endtask

  task automatic random_phase(input int n);
    logic [1:0] m;
    m = (n < 0) ? MODE_BAD : 2'($urandom_range(2));
    write_reg(REG_SHAPE_MODE, 32'(m));
    write_reg(REG_SEGS_U, $urandom_range(9) == 0 ? 32'($urandom_range(255)) : 32'($urandom_range(1, 12)));
    write_reg(REG_SEGS_V, $urandom_range(9) == 0 ? 32'($urandom_range(255)) : 32'($urandom_range(0, 12)));
    write_reg(REG_ORIGIN_X, $urandom);
    write_reg(REG_ORIGIN_Y, $urandom);
    write_reg(REG_EXTENT_X, 32'(rand_size()));
    write_reg(REG_EXTENT_Y, 32'(rand_size()));
    write_reg(REG_RADIUS, 32'(rand_size()));
    repeat ((n < 0) ? 10 : n) push_random();
    drain();
  endtask

  initial begin
    sh_mode = MODE_PLANE; sh_su = 1; sh_sv = 1; sh_ox = 0; sh_oy = 0;
    sh_ex = 65536; sh_ey = 65536; sh_rad = 65536;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: plane extremes with saturation and out-of-range points
    write_reg(REG_SEGS_U, 255);
    write_reg(REG_SEGS_V, 0);
    write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(REG_EXTENT_X, 32'h7FFF_FFFF);
    write_reg(REG_EXTENT_Y, 32'h7FFF_FFFF);
    pending_pts.push_back('{3'd7, 8'd255, 8'd1});
    pending_pts.push_back('{3'd0, 8'd0, 8'd0});
    pending_pts.push_back('{3'd0, 8'd128, 8'd2});
    pending_pts.push_back('{3'd5, 8'd255, 8'd255});
    drain();
    // Directed: sphere poles and equator at maximum radius
    write_reg(REG_SHAPE_MODE, MODE_SPHERE);
    write_reg(REG_SEGS_U, 4);
    write_reg(REG_SEGS_V, 2);
    write_reg(REG_RADIUS, 32'h7FFF_FFFF);
    for (int c = 0; c <= 4; c++) pending_pts.push_back('{3'd6, 8'(c), 8'(c % 3)});
    drain();
    // Directed: every cube face, a bad face and an out-of-range column, segs_v ignored
    write_reg(REG_SHAPE_MODE, MODE_CUBE);
    write_reg(REG_SEGS_U, 3);
    write_reg(REG_SEGS_V, 1);
    write_reg(REG_EXTENT_X, 131073);
    for (int f = 0; f <= 6; f++) pending_pts.push_back('{3'(f), 8'(f % 4), 8'(3 - f % 4)});
    pending_pts.push_back('{3'd0, 8'd4, 8'd0});
    drain();
    random_phase(-1);

    // Random phases under three idling profiles
    send_idle_pct = 32; recv_idle_pct = 54;
    repeat (4) random_phase(70);
    send_idle_pct = 54; recv_idle_pct = 32;
    repeat (4) random_phase(70);
    send_idle_pct = 0; recv_idle_pct = 0;
    // Long receiver hold-off while points keep coming
    hold_off_cycles = 80;
    repeat (3) random_phase(80);
    hold_off_cycles = 60;
    repeat (2) random_phase(70);
    drain();

    if (fail_count == 0 && expected_verts.size() == 0) begin
      $display("primitive_mesh_vertex_generator regression: pass");
    end else begin
      $display("primitive_mesh_vertex_generator regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("primitive_mesh_vertex_generator regression: fail");
    $finish;
  end

endmodule
